/* rtl/softened_gravity_accumulator_defines.svh */
`ifndef SOFTENED_GRAVITY_ACCUMULATOR_DEFINES_SVH
`define SOFTENED_GRAVITY_ACCUMULATOR_DEFINES_SVH

// Checks that a condition holds in the same cycle as its trigger.
`define SGA_ASSERT_SAME(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Checks that a condition holds in the cycle after its trigger.
`define SGA_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

/* rtl/sga_pkg.sv */
`timescale 1ns / 1ps

package sga_pkg;

    localparam int POS_W      = 32;
    localparam int ACC_W      = 64;
    localparam int MASS_W     = 32;
    localparam int MAG_W      = POS_W + 1;
    localparam int SQ_W       = 2 * MAG_W;
    localparam int R2_W       = SQ_W;
    localparam int ROOT_W     = R2_W / 2;
    localparam int REM_S_W    = ROOT_W + 3;
    localparam int NM_W       = MAG_W + MASS_W;
    localparam int FRAC_SHIFT = 48;
    localparam int NUM_W      = NM_W + FRAC_SHIFT;
    localparam int DEN_W      = R2_W + ROOT_W;
    localparam int QUO_W      = ACC_W - 1;
    localparam int SOFT_W     = 32;
    localparam int CNT_W      = 6;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int MUL_STEPS  = ROOT_W;
    localparam int DIV_STEPS  = QUO_W;
    localparam int FIFO_DEPTH = 2;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 64;
    localparam logic [SOFT_W-1:0] SOFT_RESET = 32'd1638;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_TARGET_X   = 3'd0,
        REG_TARGET_Y   = 3'd1,
        REG_TARGET_Z   = 3'd2,
        REG_BASE_ACC_X = 3'd3,
        REG_BASE_ACC_Y = 3'd4,
        REG_BASE_ACC_Z = 3'd5,
        REG_SOFTENING  = 3'd6
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PROD,
        ST_R2,
        ST_SQRT,
        ST_MUL,
        ST_DINIT,
        ST_DIV,
        ST_ACC,
        ST_OUT
    } back_state_t;

    typedef struct packed {
        logic [2:0][MAG_W-1:0] mag;
        logic [2:0]            neg;
        logic [MASS_W-1:0]     mass;
        logic                  last;
    } body_t;

    function automatic logic signed [ACC_W-1:0] sat_add(
        input logic signed [ACC_W-1:0] a,
        input logic signed [ACC_W-1:0] b
    );
        logic signed [ACC_W:0] s;
        s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
        if (s[ACC_W] != s[ACC_W-1])
        begin
            sat_add = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end
        else
        begin
            sat_add = s[ACC_W-1:0];
        end
    endfunction

endpackage

/* rtl/softened_gravity_accumulator.sv */
`timescale 1ns / 1ps

// Channel   Direction  Beat contents
// s_axis    in         tdata: body_x, body_y, body_z, body_mass; tlast: last_body
// m_axis    out        tdata: acc_x, acc_y, acc_z (one beat per run)
// cfg       in         cfg_we, cfg_addr (register index), cfg_wdata
//
// In the back end each body runs through the bit-serial square root, the shift-add
// r2 * r product and the 63-step divider, in that order.
// A body whose r2 is zero skips straight to the sums.
// After a run's last body, ST_OUT loads the result register when output is free.
// A two-entry queue lets the input take bodies while the back end is busy.
// Reset clears the sums, the queue and the output valid; softening resets to 1638.

module softened_gravity_accumulator (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // body_x [31:0], body_y [63:32], body_z [95:64], body_mass [127:96]
    input  logic [127:0]                       s_axis_tdata,
    input  logic                               s_axis_tlast,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // acc_x [63:0], acc_y [127:64], acc_z [191:128]
    output logic [191:0]                       m_axis_tdata,
    input  logic                               cfg_we,
    input  logic [sga_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [sga_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    logic [2:0][sga_pkg::POS_W-1:0]  target_reg;
    logic [2:0][sga_pkg::ACC_W-1:0]  base_reg;
    logic [sga_pkg::SOFT_W-1:0]      soft_reg;
    logic [2:0][sga_pkg::ACC_W-1:0]  out_acc;

    logic           q_full;
    logic           q_push;
    logic           q_pop;
    logic           q_valid;
    sga_pkg::body_t q_in;
    sga_pkg::body_t q_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= '0;
            base_reg   <= '0;
            soft_reg   <= sga_pkg::SOFT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                sga_pkg::REG_TARGET_X:   target_reg[0] <= cfg_wdata[sga_pkg::POS_W-1:0];
                sga_pkg::REG_TARGET_Y:   target_reg[1] <= cfg_wdata[sga_pkg::POS_W-1:0];
                sga_pkg::REG_TARGET_Z:   target_reg[2] <= cfg_wdata[sga_pkg::POS_W-1:0];
                sga_pkg::REG_BASE_ACC_X: base_reg[0]   <= cfg_wdata[sga_pkg::ACC_W-1:0];
                sga_pkg::REG_BASE_ACC_Y: base_reg[1]   <= cfg_wdata[sga_pkg::ACC_W-1:0];
                sga_pkg::REG_BASE_ACC_Z: base_reg[2]   <= cfg_wdata[sga_pkg::ACC_W-1:0];
                sga_pkg::REG_SOFTENING:  soft_reg      <= cfg_wdata[sga_pkg::SOFT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    sga_front u_front (
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_data  (s_axis_tdata),
        .in_last  (s_axis_tlast),
        .target   (target_reg),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_in)
    );

    sga_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_data  (q_out)
    );

    sga_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_data    (q_out),
        .q_pop     (q_pop),
        .softening (soft_reg),
        .base_acc  (base_reg),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_acc   (out_acc)
    );

    assign m_axis_tdata = {out_acc[2], out_acc[1], out_acc[0]};

endmodule

/* rtl/sga_front.sv */
`timescale 1ns / 1ps

module sga_front (
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [3*sga_pkg::POS_W+sga_pkg::MASS_W-1:0] in_data,
    input  logic                                  in_last,
    input  logic [2:0][sga_pkg::POS_W-1:0]        target,
    input  logic                                  q_full,
    output logic                                  q_push,
    output sga_pkg::body_t                        q_data
);

    logic signed [sga_pkg::MAG_W-1:0] diff [3];
    logic [sga_pkg::POS_W-1:0]        pos  [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pos[i]  = in_data[i*sga_pkg::POS_W +: sga_pkg::POS_W];
            diff[i] = $signed({pos[i][sga_pkg::POS_W-1], pos[i]})
                    - $signed({target[i][sga_pkg::POS_W-1], target[i]});
            q_data.neg[i] = diff[i][sga_pkg::MAG_W-1];
            q_data.mag[i] = diff[i][sga_pkg::MAG_W-1] ? sga_pkg::MAG_W'(-diff[i])
                                                      : sga_pkg::MAG_W'(diff[i]);
        end
        q_data.mass = in_data[3*sga_pkg::POS_W +: sga_pkg::MASS_W];
        q_data.last = in_last;
    end

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

endmodule

/* rtl/sga_fifo.sv */
`timescale 1ns / 1ps
`include "softened_gravity_accumulator_defines.svh"

module sga_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  sga_pkg::body_t push_data,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output sga_pkg::body_t pop_data
);

    sga_pkg::body_t                 mem_reg [sga_pkg::FIFO_DEPTH];
    logic [sga_pkg::PTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [sga_pkg::PTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [sga_pkg::FCNT_W-1:0]     count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign full      = (count_reg == sga_pkg::FCNT_W'(sga_pkg::FIFO_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    `SGA_ASSERT_SAME(a_no_overflow, push, !full, "fifo written while full")
    `SGA_ASSERT_SAME(a_no_underflow, pop, not_empty, "fifo read while empty")

endmodule

/* rtl/sga_back.sv */
`timescale 1ns / 1ps
`include "softened_gravity_accumulator_defines.svh"

module sga_back (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       q_valid,
    input  sga_pkg::body_t                             q_data,
    output logic                                       q_pop,
    input  logic [sga_pkg::SOFT_W-1:0]                 softening,
    input  logic [2:0][sga_pkg::ACC_W-1:0]             base_acc,
    output logic                                       out_valid,
    input  logic                                       out_ready,
    output logic [2:0][sga_pkg::ACC_W-1:0]             out_acc
);

    localparam logic [sga_pkg::ACC_W-1:0] ACC_MAX = {1'b0, {(sga_pkg::ACC_W-1){1'b1}}};
    localparam logic [sga_pkg::ACC_W-1:0] ACC_MIN = {1'b1, {(sga_pkg::ACC_W-1){1'b0}}};

    sga_pkg::back_state_t state_reg, state_next;
    sga_pkg::body_t       ent_reg, ent_next;

    logic [2:0][sga_pkg::SQ_W-1:0]    sq_reg, sq_next;
    logic [2:0][sga_pkg::NM_W-1:0]    nm_reg, nm_next;
    logic [sga_pkg::R2_W-1:0]         r2_reg, r2_next;
    logic [sga_pkg::R2_W-1:0]         src_reg, src_next;
    logic [sga_pkg::REM_S_W-1:0]      rem_s_reg, rem_s_next;
    logic [sga_pkg::ROOT_W-1:0]       root_reg, root_next;
    logic [sga_pkg::ROOT_W-1:0]       msh_reg, msh_next;
    logic [sga_pkg::DEN_W-1:0]        den_reg, den_next;
    logic [2:0][sga_pkg::DEN_W-1:0]   rem_reg, rem_next;
    logic [2:0][sga_pkg::QUO_W-1:0]   nl_reg, nl_next;
    logic [2:0][sga_pkg::QUO_W-1:0]   quo_reg, quo_next;
    logic [2:0]                       sat_reg, sat_next;
    logic [sga_pkg::CNT_W-1:0]        cnt_reg, cnt_next;
    logic                             zero_reg, zero_next;
    logic [2:0][sga_pkg::ACC_W-1:0]   sum_reg, sum_next;
    logic [2:0][sga_pkg::ACC_W-1:0]   out_reg, out_next;
    logic                             out_valid_reg, out_valid_next;

    logic [sga_pkg::R2_W-1:0]         r2_sum;
    logic [sga_pkg::REM_S_W-1:0]      s_rem2;
    logic [sga_pkg::REM_S_W-1:0]      s_trial;
    logic [sga_pkg::NUM_W-1:0]        num;
    logic [sga_pkg::DEN_W:0]          d_rem2;
    logic [sga_pkg::ACC_W-1:0]        term;
    logic                             out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        ent_next       = ent_reg;
        sq_next        = sq_reg;
        nm_next        = nm_reg;
        r2_next        = r2_reg;
        src_next       = src_reg;
        rem_s_next     = rem_s_reg;
        root_next      = root_reg;
        msh_next       = msh_reg;
        den_next       = den_reg;
        rem_next       = rem_reg;
        nl_next        = nl_reg;
        quo_next       = quo_reg;
        sat_next       = sat_reg;
        cnt_next       = cnt_reg;
        zero_next      = zero_reg;
        sum_next       = sum_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        q_pop          = 1'b0;
        r2_sum         = '0;
        s_rem2         = '0;
        s_trial        = '0;
        num            = '0;
        d_rem2         = '0;
        term           = '0;

        case (state_reg)
            sga_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    ent_next   = q_data;
                    state_next = sga_pkg::ST_PROD;
                end
            end
            sga_pkg::ST_PROD:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    sq_next[i] = sga_pkg::SQ_W'(ent_reg.mag[i] * ent_reg.mag[i]);
                    nm_next[i] = sga_pkg::NM_W'(ent_reg.mag[i] * ent_reg.mass);
                end
                state_next = sga_pkg::ST_R2;
            end
            sga_pkg::ST_R2:
            begin
                r2_sum = sq_reg[0] + sq_reg[1] + sq_reg[2]
                       + sga_pkg::R2_W'({softening, 16'b0});
                r2_next    = r2_sum;
                src_next   = r2_sum;
                rem_s_next = '0;
                root_next  = '0;
                cnt_next   = '0;
                zero_next  = (r2_sum == '0);
                state_next = (r2_sum == '0) ? sga_pkg::ST_ACC : sga_pkg::ST_SQRT;
            end
            sga_pkg::ST_SQRT:
            begin
                s_rem2  = {rem_s_reg[sga_pkg::REM_S_W-3:0], src_reg[sga_pkg::R2_W-1 -: 2]};
                s_trial = sga_pkg::REM_S_W'({root_reg, 2'b01});
                if (s_rem2 >= s_trial)
                begin
                    rem_s_next = s_rem2 - s_trial;
                    root_next  = {root_reg[sga_pkg::ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_s_next = s_rem2;
                    root_next  = {root_reg[sga_pkg::ROOT_W-2:0], 1'b0};
                end
                src_next = {src_reg[sga_pkg::R2_W-3:0], 2'b00};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == sga_pkg::CNT_W'(sga_pkg::SQRT_STEPS - 1))
                begin
                    cnt_next   = '0;
                    den_next   = '0;
                    msh_next   = root_next;
                    state_next = sga_pkg::ST_MUL;
                end
            end
            sga_pkg::ST_MUL:
            begin
                den_next = {den_reg[sga_pkg::DEN_W-2:0], 1'b0}
                         + (msh_reg[sga_pkg::ROOT_W-1] ? sga_pkg::DEN_W'(r2_reg) : '0);
                msh_next = {msh_reg[sga_pkg::ROOT_W-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == sga_pkg::CNT_W'(sga_pkg::MUL_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = sga_pkg::ST_DINIT;
                end
            end
            sga_pkg::ST_DINIT:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    num         = {nm_reg[i], {sga_pkg::FRAC_SHIFT{1'b0}}};
                    sat_next[i] = ((sga_pkg::DEN_W + sga_pkg::QUO_W)'(num)
                                  >= {den_reg, {sga_pkg::QUO_W{1'b0}}});
                    rem_next[i] = sga_pkg::DEN_W'(num[sga_pkg::NUM_W-1:sga_pkg::QUO_W]);
                    nl_next[i]  = num[sga_pkg::QUO_W-1:0];
                    quo_next[i] = '0;
                end
                state_next = sga_pkg::ST_DIV;
            end
            sga_pkg::ST_DIV:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    d_rem2     = {rem_reg[i], nl_reg[i][sga_pkg::QUO_W-1]};
                    nl_next[i] = {nl_reg[i][sga_pkg::QUO_W-2:0], 1'b0};
                    if (d_rem2 >= {1'b0, den_reg})
                    begin
                        rem_next[i] = sga_pkg::DEN_W'(d_rem2 - {1'b0, den_reg});
                        quo_next[i] = {quo_reg[i][sga_pkg::QUO_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next[i] = sga_pkg::DEN_W'(d_rem2);
                        quo_next[i] = {quo_reg[i][sga_pkg::QUO_W-2:0], 1'b0};
                    end
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == sga_pkg::CNT_W'(sga_pkg::DIV_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = sga_pkg::ST_ACC;
                end
            end
            sga_pkg::ST_ACC:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (zero_reg)
                    begin
                        term = '0;
                    end
                    else if (sat_reg[i])
                    begin
                        term = ent_reg.neg[i] ? ACC_MIN : ACC_MAX;
                    end
                    else
                    begin
                        term = ent_reg.neg[i] ? -{1'b0, quo_reg[i]} : {1'b0, quo_reg[i]};
                    end
                    sum_next[i] = sga_pkg::sat_add(sum_reg[i], term);
                end
                state_next = ent_reg.last ? sga_pkg::ST_OUT : sga_pkg::ST_IDLE;
            end
            sga_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        out_next[i] = sga_pkg::sat_add(base_acc[i], sum_reg[i]);
                        sum_next[i] = '0;
                    end
                    out_valid_next = 1'b1;
                    state_next     = sga_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sga_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sga_pkg::ST_IDLE;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg   <= ent_next;
        sq_reg    <= sq_next;
        nm_reg    <= nm_next;
        r2_reg    <= r2_next;
        src_reg   <= src_next;
        rem_s_reg <= rem_s_next;
        root_reg  <= root_next;
        msh_reg   <= msh_next;
        den_reg   <= den_next;
        rem_reg   <= rem_next;
        nl_reg    <= nl_next;
        quo_reg   <= quo_next;
        sat_reg   <= sat_next;
        zero_reg  <= zero_next;
        out_reg   <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_acc   = out_reg;

    `SGA_ASSERT_NEXT(a_pop_starts_body, (state_reg == sga_pkg::ST_IDLE) && q_valid,
        state_reg == sga_pkg::ST_PROD, "queued body not taken up")
    `SGA_ASSERT_NEXT(a_result_loaded, (state_reg == sga_pkg::ST_OUT) && out_free,
        out_valid_reg && (sum_reg == '0), "run result not presented")

endmodule
